>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that is checked on every rising clock edge outside reset.
`define WSPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A property with an enabling condition and a next-cycle consequence.
`define WSPD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> hw/rtl/wspd_pkg.sv
// Shared types, constants and helper functions for the wheel speed to duty block.
// No dependencies; the top level and the checker import it.
package wspd_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 40;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_RPM_PER_SPEED = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DUTY      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DUTY      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_MV  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_COMP  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOPE_COMP    = 3'd5;

    localparam logic [15:0] RPM_PER_SPEED_RST = 16'd24448;
    localparam logic [15:0] MIN_DUTY_RST      = 16'd0;
    localparam logic [15:0] MAX_DUTY_RST      = 16'd65535;
    localparam logic [13:0] REFERENCE_MV_RST  = 14'd12000;

    // Item kinds carried on s_tuser.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic [15:0] SPEED_ZERO_TH = 16'd41;   // 0.01 m/s in Q4.12
    localparam logic [15:0] RPM_STOP_TH   = 16'd160;  // 10 rpm in Q12.4
    localparam logic [13:0] VBAT_MIN_MV   = 14'd9000;
    localparam logic [13:0] VBAT_MAX_MV   = 14'd12600;
    localparam logic [9:0]  PITCH_LIMIT   = 10'd520;

    // 0.8 * pitch / 1000 in Q2.14 is pitch * 8192 / 625 = 13 * pitch + 67 * pitch / 625.
    localparam int SLOPE_ONE      = 16384;
    localparam int SLOPE_INT_MUL  = 13;
    localparam int SLOPE_FRAC_MUL = 67;
    localparam int SLOPE_RECIP    = 107375;   // ceil(2^26 / 625)
    localparam int SLOPE_RECIP_SH = 26;

    localparam int INTERP_DIV_STEPS = 16;
    localparam int BATT_DIV_STEPS   = 17;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP0,
        ST_PREP1,
        ST_WHEEL,
        ST_SCAN,
        ST_DECIDE,
        ST_DIV,
        ST_DIV_END,
        ST_COMP,
        ST_SLOPE,
        ST_DONE
    } state_t;

    typedef enum logic {
        DIV_INTERP,
        DIV_BATT
    } div_use_t;

    // Saturate to the ceiling, and lift a nonzero duty to the floor.
    function automatic logic [15:0] clip_duty(input logic [16:0] d,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
        logic [15:0] r;
        if (d > {1'b0, hi})
            r = hi;
        else if (d != 17'd0 && d < {1'b0, lo})
            r = lo;
        else
            r = d[15:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/wspd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the breakpoint table.
module wspd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/wheel_speed_to_pwm_duty.sv
// Top level of the wheel speed to PWM duty converter.
// Uses wspd_pkg and one wspd_ram instance for the breakpoint table.

// A load beat (s_tuser = 0) writes one (rpm, duty) breakpoint into the table RAM and gives
// no result. A convert beat (s_tuser = 1) gives one result beat with a direction bit and a
// duty per wheel. The two wheels run one after the other through the same datapath: a table
// walk that streams all TABLE_ENTRIES entries out of the RAM at one per cycle, a 16-step
// serial divider for the interpolation and a 17-step pass of the same divider for battery
// compensation. A wheel may skip the interpolation, and the battery pass is left out when
// battery compensation is off. The input is not ready while a convert beat is in work; a
// finished result waits in the output register without blocking the next beat, whose own
// result is held back until the waiting one is taken.
module wheel_speed_to_pwm_duty
    import wspd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_index[2:0], entry_rpm[18:3], entry_duty[34:19], speed_right[50:35],
    // speed_left[66:51], battery_mv[80:67], pitch_mrad[91:81], zeros above
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // cmd: 0 load breakpoint, 1 convert
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // reverse_right[0], reverse_left[1], duty_right[17:2], duty_left[33:18], zeros above
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] SCAN_END = CW'(TABLE_ENTRIES);

    // Input fields.
    logic [2:0]         in_entry_index;
    logic [15:0]        in_entry_rpm;
    logic [15:0]        in_entry_duty;
    logic signed [15:0] in_speed_right;
    logic signed [15:0] in_speed_left;
    logic [13:0]        in_battery_mv;
    logic signed [10:0] in_pitch_mrad;

    assign in_entry_index = s_tdata[2:0];
    assign in_entry_rpm   = s_tdata[18:3];
    assign in_entry_duty  = s_tdata[34:19];
    assign in_speed_right = s_tdata[50:35];
    assign in_speed_left  = s_tdata[66:51];
    assign in_battery_mv  = s_tdata[80:67];
    assign in_pitch_mrad  = s_tdata[91:81];

    // Configuration.
    logic [15:0] rpm_per_speed_reg;
    logic [15:0] min_duty_reg;
    logic [15:0] max_duty_reg;
    logic [13:0] reference_mv_reg;
    logic        battery_comp_reg;
    logic        slope_comp_reg;

    state_t state_reg;
    state_t state_next;

    logic        in_accept;
    logic        load_we;
    logic        ram_re;
    logic [31:0] ram_rdata;

    // Item operands.
    logic [15:0] speed_right_reg;
    logic [15:0] speed_left_reg;
    logic [13:0] vbat_reg;
    logic        pitch_neg_reg;
    logic [9:0]  pitch_abs_reg;
    logic [15:0] slope_y_reg;
    logic [14:0] slope_f_reg;
    logic        wheel_sel_reg;

    // Per-wheel working state.
    logic [15:0] rpm_reg;
    logic        small_reg;
    logic [CW-1:0] scan_cnt_reg;
    logic        rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [15:0] prev_rpm_reg;
    logic [15:0] prev_duty_reg;
    logic        found_reg;
    logic        below1_reg;
    logic        atlast_reg;
    logic [15:0] seg_off_reg;
    logic [15:0] seg_span_reg;
    logic [15:0] seg_dd_reg;
    logic        seg_neg_reg;
    logic [15:0] seg_dlo_reg;
    logic [15:0] duty_reg;
    logic [15:0] duty_right_reg;

    // Serial divider.
    div_use_t    div_use_reg;
    logic [15:0] div_rem_reg;
    logic [31:0] div_low_reg;
    logic [16:0] div_q_reg;
    logic [4:0]  div_cnt_reg;
    logic [15:0] div_dsr_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // Combinational helpers.
    logic [15:0] wheel_speed;
    logic [15:0] wheel_mag;
    logic [31:0] rpm_prod;
    logic [31:0] interp_prod;
    logic [29:0] batt_prod;
    logic [30:0] slope_prod;
    logic [16:0] div_trial;
    logic        div_ge;
    logic [15:0] slope_duty;
    logic [15:0] final_duty;
    logic [33:0] recip_prod;
    logic [12:0] slope_mag;
    logic [15:0] cur_rpm;
    logic [15:0] cur_duty;
    logic [13:0] vbat_clamped;
    logic        pitch_neg;
    logic [10:0] pitch_abs;

    assign in_accept = s_tvalid && s_tready;
    assign load_we   = in_accept && (s_tuser == CMD_LOAD)
                       && (32'(in_entry_index) < TABLE_ENTRIES);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cur_rpm   = ram_rdata[15:0];
    assign cur_duty  = ram_rdata[31:16];

    wspd_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(in_entry_index)),
        .wdata ({in_entry_duty, in_entry_rpm}),
        .re    (ram_re),
        .raddr (scan_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        vbat_clamped = in_battery_mv;
        if (in_battery_mv < VBAT_MIN_MV)
            vbat_clamped = VBAT_MIN_MV;
        else if (in_battery_mv > VBAT_MAX_MV)
            vbat_clamped = VBAT_MAX_MV;
        pitch_neg = in_pitch_mrad[10];
        pitch_abs = pitch_neg ? 11'(-in_pitch_mrad) : 11'(in_pitch_mrad);

        wheel_speed = wheel_sel_reg ? speed_left_reg : speed_right_reg;
        wheel_mag   = wheel_speed[15] ? 16'(-wheel_speed) : wheel_speed;
        rpm_prod    = 32'(wheel_mag) * 32'(rpm_per_speed_reg);
        interp_prod = 32'(seg_off_reg) * 32'(seg_dd_reg);
        batt_prod   = 30'(duty_reg) * 30'(reference_mv_reg);
        slope_prod  = 31'(duty_reg) * 31'(slope_f_reg);
        recip_prod  = 34'(slope_y_reg) * 34'(SLOPE_RECIP);
        slope_mag   = 13'(32'(pitch_abs_reg) * SLOPE_INT_MUL)
                      + 13'(recip_prod >> SLOPE_RECIP_SH);

        div_trial = {div_rem_reg, div_low_reg[31]};
        div_ge    = div_trial >= {1'b0, div_dsr_reg};

        slope_duty = slope_comp_reg ? clip_duty(17'(slope_prod >> 14), min_duty_reg,
                                                max_duty_reg)
                                    : duty_reg;
        final_duty = clip_duty({1'b0, slope_duty}, min_duty_reg, max_duty_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tuser == CMD_CONVERT)
                    state_next = ST_PREP0;
            end
            ST_PREP0:   state_next = ST_PREP1;
            ST_PREP1:   state_next = ST_WHEEL;
            ST_WHEEL:   state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (rd_vld_reg && rd_idx_reg == LAST_IDX)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (small_reg || below1_reg || atlast_reg || !found_reg)
                    state_next = ST_COMP;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 5'd1)
                    state_next = ST_DIV_END;
            end
            ST_DIV_END:
            begin
                if (div_use_reg == DIV_INTERP)
                    state_next = ST_COMP;
                else
                    state_next = ST_SLOPE;
            end
            ST_COMP:
            begin
                if (battery_comp_reg)
                    state_next = ST_DIV;
                else
                    state_next = ST_SLOPE;
            end
            ST_SLOPE:
            begin
                if (wheel_sel_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_WHEEL;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // State-driven outputs.
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        ram_re   = (state_reg == ST_SCAN) && (scan_cnt_reg < SCAN_END);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            rpm_per_speed_reg <= RPM_PER_SPEED_RST;
            min_duty_reg      <= MIN_DUTY_RST;
            max_duty_reg      <= MAX_DUTY_RST;
            reference_mv_reg  <= REFERENCE_MV_RST;
            battery_comp_reg  <= 1'b0;
            slope_comp_reg    <= 1'b0;
            wheel_sel_reg     <= 1'b0;
            rd_vld_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= ram_re;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RPM_PER_SPEED: rpm_per_speed_reg <= cfg_data;
                    REG_MIN_DUTY:      min_duty_reg      <= cfg_data;
                    REG_MAX_DUTY:      max_duty_reg      <= cfg_data;
                    REG_REFERENCE_MV:  reference_mv_reg  <= cfg_data[13:0];
                    REG_BATTERY_COMP:  battery_comp_reg  <= cfg_data[0];
                    REG_SLOPE_COMP:    slope_comp_reg    <= cfg_data[0];
                    default:           ;
                endcase
            end

            if (state_reg == ST_PREP0)
                wheel_sel_reg <= 1'b0;
            else if (state_reg == ST_SLOPE)
                wheel_sel_reg <= !wheel_sel_reg;

            if (state_reg == ST_DONE && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && s_tuser == CMD_CONVERT)
                begin
                    speed_right_reg <= in_speed_right;
                    speed_left_reg  <= in_speed_left;
                    vbat_reg        <= vbat_clamped;
                    pitch_neg_reg   <= pitch_neg;
                    pitch_abs_reg   <= (pitch_abs > 11'(PITCH_LIMIT)) ? PITCH_LIMIT
                                                                      : pitch_abs[9:0];
                end
            end
            ST_PREP0:
            begin
                slope_y_reg <= 16'(32'(pitch_abs_reg) * SLOPE_FRAC_MUL);
            end
            ST_PREP1:
            begin
                slope_f_reg <= pitch_neg_reg ? 15'(SLOPE_ONE - 32'(slope_mag))
                                             : 15'(SLOPE_ONE + 32'(slope_mag));
            end
            ST_WHEEL:
            begin
                rpm_reg      <= rpm_prod[31:16];
                small_reg    <= wheel_mag < SPEED_ZERO_TH;
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            ST_SCAN:
            begin
                if (ram_re)
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                rd_idx_reg <= scan_cnt_reg[AW-1:0];
                if (rd_vld_reg)
                begin
                    // The first segment that holds rpm wins.
                    if (rd_idx_reg != '0 && !found_reg && rpm_reg >= prev_rpm_reg
                        && rpm_reg < cur_rpm)
                    begin
                        found_reg    <= 1'b1;
                        seg_off_reg  <= rpm_reg - prev_rpm_reg;
                        seg_span_reg <= cur_rpm - prev_rpm_reg;
                        seg_neg_reg  <= cur_duty < prev_duty_reg;
                        seg_dd_reg   <= (cur_duty < prev_duty_reg) ? prev_duty_reg - cur_duty
                                                                   : cur_duty - prev_duty_reg;
                        seg_dlo_reg  <= prev_duty_reg;
                    end
                    if (rd_idx_reg == AW'(1))
                        below1_reg <= rpm_reg < cur_rpm;
                    if (rd_idx_reg == LAST_IDX)
                        atlast_reg <= rpm_reg >= cur_rpm;
                    prev_rpm_reg  <= cur_rpm;
                    prev_duty_reg <= cur_duty;
                end
            end
            ST_DECIDE:
            begin
                if (small_reg)
                    duty_reg <= '0;
                else if (below1_reg)
                    duty_reg <= (rpm_reg < RPM_STOP_TH) ? 16'd0 : min_duty_reg;
                else if (atlast_reg)
                    duty_reg <= max_duty_reg;
                else if (!found_reg)
                    duty_reg <= min_duty_reg;
                else
                begin
                    // The quotient is below 2^16, so the top half starts as the remainder.
                    div_use_reg <= DIV_INTERP;
                    div_rem_reg <= interp_prod[31:16];
                    div_low_reg <= {interp_prod[15:0], 16'd0};
                    div_q_reg   <= '0;
                    div_cnt_reg <= 5'(INTERP_DIV_STEPS);
                    div_dsr_reg <= seg_span_reg;
                end
            end
            ST_DIV:
            begin
                div_rem_reg <= div_ge ? 16'(div_trial - {1'b0, div_dsr_reg})
                                      : div_trial[15:0];
                div_low_reg <= {div_low_reg[30:0], 1'b0};
                div_q_reg   <= {div_q_reg[15:0], div_ge};
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            ST_DIV_END:
            begin
                if (div_use_reg == DIV_INTERP)
                    duty_reg <= seg_neg_reg ? seg_dlo_reg - div_q_reg[15:0]
                                            : seg_dlo_reg + div_q_reg[15:0];
                else
                    duty_reg <= clip_duty(div_q_reg, min_duty_reg, max_duty_reg);
            end
            ST_COMP:
            begin
                if (battery_comp_reg)
                begin
                    // The battery voltage is at least 9000, so the top 13 bits start below it.
                    div_use_reg <= DIV_BATT;
                    div_rem_reg <= 16'(batt_prod[29:17]);
                    div_low_reg <= {batt_prod[16:0], 15'd0};
                    div_q_reg   <= '0;
                    div_cnt_reg <= 5'(BATT_DIV_STEPS);
                    div_dsr_reg <= 16'(vbat_reg);
                end
            end
            ST_SLOPE:
            begin
                if (!wheel_sel_reg)
                    duty_right_reg <= final_duty;
                else
                    duty_reg <= final_duty;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    out_data_reg <= M_TDATA_W'({duty_reg, duty_right_reg,
                                                speed_left_reg[15], speed_right_reg[15]});
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> hw/rtl/wspd_checker.sv
// Port-level checker for wheel_speed_to_pwm_duty, bound to every instance.
// Depends on assert_macros.svh and wspd_pkg.
`include "assert_macros.svh"

module wspd_checker
    import wspd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A result beat that is held back keeps its value.
    `WSPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A load beat that is accepted while no result is waiting produces no result.
    `WSPD_ASSERT_NEXT(a_load_silent, s_tvalid && s_tready && s_tuser == CMD_LOAD && !m_tvalid, !m_tvalid, "load beat produced a result")

    // A convert beat makes the block busy in the next cycle.
    `WSPD_ASSERT_NEXT(a_convert_busy, s_tvalid && s_tready && s_tuser == CMD_CONVERT, !s_tready, "input still ready after a convert beat")

    // A new result only appears after a busy cycle.
    `WSPD_ASSERT(a_result_after_work, $rose(m_tvalid) |-> $past(!s_tready), "result without work")

endmodule

bind wheel_speed_to_pwm_duty wspd_checker u_wspd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
